// ===== rtl/rv64ie_pkg.sv =====
// Package with shared types, kind codes and opcodes for the RV64I execute unit.
`timescale 1ns / 1ps
package rv64ie_pkg;
  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_READ    = 3'd1,
    KIND_WRITE   = 3'd2,
    KIND_ILLEGAL = 3'd3,
    KIND_SYSTEM  = 3'd4
  } kind_t;

  localparam logic [4:0] OP_LOAD   = 5'h00;
  localparam logic [4:0] OP_FENCE  = 5'h03;
  localparam logic [4:0] OP_IMM    = 5'h04;
  localparam logic [4:0] OP_AUIPC  = 5'h05;
  localparam logic [4:0] OP_IMM32  = 5'h06;
  localparam logic [4:0] OP_STORE  = 5'h08;
  localparam logic [4:0] OP_AMO    = 5'h0B;
  localparam logic [4:0] OP_REG    = 5'h0C;
  localparam logic [4:0] OP_LUI    = 5'h0D;
  localparam logic [4:0] OP_REG32  = 5'h0E;
  localparam logic [4:0] OP_BRANCH = 5'h18;
  localparam logic [4:0] OP_JALR   = 5'h19;
  localparam logic [4:0] OP_JAL    = 5'h1B;
  localparam logic [4:0] OP_SYSTEM = 5'h1C;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MUL  = 7'b0000001;
  localparam logic [5:0] TOP_SRA = 6'b010000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] mem_addr;
    logic [1:0]  mem_size;
    logic [63:0] store_value;
    logic [63:0] next_pc;
  } result_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [63:0] data;
  } reg_write_t;
endpackage

// ===== rtl/rv64i_integer_execute.sv =====
// Top level of the RV64I execute unit: register file read stage, execute stage, output register.
// An accepted transaction is registered in the execute stage and then in the output register;
// a mul stays in the execute stage while its partial products are registered.
// One transaction per cycle unless the output stalls or a mul waits; the register file reads in the
// accept cycle and the write of the execute stage is forwarded to the next instruction.
// Reset: synchronous; registers read as zero until written, pc and pending load clear.
`timescale 1ns / 1ps
module rv64i_integer_execute #(
  parameter int REG_COUNT = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // mode, instr_word, load_data, zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata    // kind, mem_addr, mem_size, store_value, next_pc, zero pad
);
  logic        s_fire;
  logic        ex_valid;
  logic        ex_mode;
  logic [31:0] ex_word;
  logic [63:0] ex_load;
  logic [4:0]  ex_rs1;
  logic [4:0]  ex_rs2;
  logic [63:0] rf_a;
  logic [63:0] rf_b;
  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] pc;
  logic [4:0]  pend_dest;
  logic [1:0]  pend_size;
  logic        pend_signed;
  logic        pend_load;
  logic        ex_fwd_valid;
  logic        stall;
  logic        ex_mul;
  logic        ex_hold;
  logic        mul_ready;
  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;
  logic [63:0] mul_prod;
  rv64ie_pkg::result_t    ex_res;
  rv64ie_pkg::reg_write_t ex_wr;
  rv64ie_pkg::reg_write_t wb;
  rv64ie_pkg::result_t    out_res;

  // Stage EX completes only if the output register is free and a mul has its products.
  assign stall    = m_tvalid && !m_tready;
  assign ex_hold  = ex_mul && !mul_ready;
  assign s_tready = !(ex_valid && (stall || ex_hold));
  assign s_fire   = s_tvalid && s_tready;
  assign ex_fwd_valid = ex_valid && !stall && !ex_hold;

  assign wb.en   = ex_fwd_valid && ex_wr.en;
  assign wb.addr = ex_wr.addr;
  assign wb.data = ex_wr.data;

  rv64ie_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk(clk), .rst(rst), .rd_en(s_fire),
    .rd_addr_a(s_tdata[20:16]), .rd_addr_b(s_tdata[25:21]),
    .wr(wb), .rd_data_a(rf_a), .rd_data_b(rf_b)
  );

  // Forwarding register for the write that retired in the same cycle as the read.
  logic        fw_en;
  logic [4:0]  fw_addr;
  logic [63:0] fw_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      fw_en    <= 1'b0;
    end else begin
      if (s_fire) ex_valid <= 1'b1;
      else if (ex_fwd_valid) ex_valid <= 1'b0;
      if (s_fire) fw_en <= wb.en && wb.addr != 5'd0 && ({27'd0, wb.addr} < REG_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      ex_mode <= s_tdata[0];
      ex_word <= s_tdata[32:1];
      ex_load <= s_tdata[96:33];
      ex_rs1  <= s_tdata[20:16];
      ex_rs2  <= s_tdata[25:21];
      fw_addr <= wb.addr;
      fw_data <= wb.data;
    end
  end

  assign op_a = (fw_en && fw_addr == ex_rs1) ? fw_data : rf_a;
  assign op_b = (fw_en && fw_addr == ex_rs2) ? fw_data : rf_b;

  // The low 64 bits of the product come from three 32 by 32 partial products.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_ready <= 1'b0;
    end else if (ex_fwd_valid) begin
      mul_ready <= 1'b0;
    end else if (ex_valid && ex_mul) begin
      mul_ready <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_valid && ex_hold) begin
      p_ll <= {32'd0, op_a[31:0]} * {32'd0, op_b[31:0]};
      p_lh <= op_a[31:0] * op_b[63:32];
      p_hl <= op_a[63:32] * op_b[31:0];
    end
  end

  assign mul_prod = p_ll + {p_lh + p_hl, 32'd0};

  rv64ie_exec u_exec (
    .mode(ex_mode), .w(ex_word), .load_data(ex_load), .a(op_a), .b(op_b), .pc(pc),
    .pend_dest(pend_dest), .pend_size(pend_size), .pend_signed(pend_signed),
    .prod(mul_prod), .res(ex_res), .wr(ex_wr), .pend_load(pend_load), .is_mul(ex_mul)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= '0;
      pend_dest   <= '0;
      pend_size   <= '0;
      pend_signed <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (ex_fwd_valid) begin
        pc <= ex_res.next_pc;
        if (pend_load) begin
          pend_dest   <= ex_word[11:7];
          pend_size   <= ex_word[13:12];
          pend_signed <= !ex_word[14];
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fwd_valid) out_res <= ex_res;
  end

  assign m_tdata = {3'd0, out_res.next_pc, out_res.store_value, out_res.mem_size,
                    out_res.mem_addr, out_res.kind};

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("output lost under stall");
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !ex_fwd_valid |=> $stable(pc)) else $error("pc moved without an instruction");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    ex_valid && stall |-> !s_fire) else $error("accepted while execute stage blocked");
  a_illegal_no_write: assert property (@(posedge clk) disable iff (rst)
    ex_fwd_valid && ex_res.kind == rv64ie_pkg::KIND_ILLEGAL |-> !wb.en)
    else $error("illegal instruction wrote a register");
endmodule

// ===== rtl/rv64ie_regfile.sv =====
// Register file memory with one write port and two registered read ports; forwarding is done by the top level.
`timescale 1ns / 1ps
module rv64ie_regfile #(
  parameter int REG_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [4:0]             rd_addr_a,
  input  logic [4:0]             rd_addr_b,
  input  rv64ie_pkg::reg_write_t wr,
  output logic [63:0]            rd_data_a,
  output logic [63:0]            rd_data_b
);
  localparam int IDX_W = $clog2(REG_COUNT);

  logic [63:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] written;
  logic [63:0] mem_a;
  logic [63:0] mem_b;
  logic        zero_a;
  logic        zero_b;
  logic        used_a;
  logic        used_b;
  logic        wr_ok;

  assign wr_ok = wr.en && (wr.addr != 5'd0) && ({27'd0, wr.addr} < REG_COUNT);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_ok) begin
      written[wr.addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_a  <= mem[rd_addr_a[IDX_W-1:0]];
      mem_b  <= mem[rd_addr_b[IDX_W-1:0]];
      zero_a <= (rd_addr_a == 5'd0) || ({27'd0, rd_addr_a} >= REG_COUNT);
      zero_b <= (rd_addr_b == 5'd0) || ({27'd0, rd_addr_b} >= REG_COUNT);
      used_a <= written[rd_addr_a[IDX_W-1:0]];
      used_b <= written[rd_addr_b[IDX_W-1:0]];
    end
  end

  assign rd_data_a = (zero_a || !used_a) ? 64'd0 : mem_a;
  assign rd_data_b = (zero_b || !used_b) ? 64'd0 : mem_b;
endmodule

// ===== rtl/rv64ie_exec.sv =====
// Combinational execute logic for one instruction or load return.
`timescale 1ns / 1ps
module rv64ie_exec (
  input  logic                   mode,
  input  logic [31:0]            w,
  input  logic [63:0]            load_data,
  input  logic [63:0]            a,
  input  logic [63:0]            b,
  input  logic [63:0]            pc,
  input  logic [4:0]             pend_dest,
  input  logic [1:0]             pend_size,
  input  logic                   pend_signed,
  input  logic [63:0]            prod,
  output rv64ie_pkg::result_t    res,
  output rv64ie_pkg::reg_write_t wr,
  output logic                   pend_load,
  output logic                   is_mul
);
  logic [4:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  top;
  logic [5:0]  sh;
  logic [63:0] immi;
  logic [63:0] imms;
  logic [63:0] immb;
  logic [63:0] immj;
  logic [63:0] immu;
  logic [63:0] v;
  logic [63:0] npc;
  logic [63:0] ld;
  logic [31:0] lo;
  logic [31:0] wv;
  logic        wen;
  logic        bad;
  logic        t;
  logic [2:0]  kind;
  logic [63:0] addr;
  logic [1:0]  size;
  logic [63:0] sval;

  assign op   = w[6:2];
  assign rd   = w[11:7];
  assign f3   = w[14:12];
  assign f7   = w[31:25];
  assign top  = w[31:26];
  assign sh   = w[25:20];
  assign immi = {{52{w[31]}}, w[31:20]};
  assign imms = {{52{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign immu = {{32{w[31]}}, w[31:12], 12'd0};
  assign lo   = a[31:0];

  // A mul is held in the execute stage until its partial products are registered.
  assign is_mul = !mode && (w[1:0] == 2'b11) && (op == rv64ie_pkg::OP_REG) &&
                  (f7 == rv64ie_pkg::F7_MUL) && (f3 == 3'd0);

  always_comb begin
    case (pend_size)
      2'd0:    ld = pend_signed ? {{56{load_data[7]}}, load_data[7:0]}
                                : {56'd0, load_data[7:0]};
      2'd1:    ld = pend_signed ? {{48{load_data[15]}}, load_data[15:0]}
                                : {48'd0, load_data[15:0]};
      2'd2:    ld = pend_signed ? {{32{load_data[31]}}, load_data[31:0]}
                                : {32'd0, load_data[31:0]};
      default: ld = load_data;
    endcase
  end

  always_comb begin
    kind = rv64ie_pkg::KIND_DONE;
    addr = '0;
    size = '0;
    sval = '0;
    v    = '0;
    wv   = '0;
    wen  = 1'b0;
    bad  = 1'b0;
    t    = 1'b0;
    pend_load = 1'b0;
    npc  = pc + 64'd4;
    if (mode) begin
      npc = pc;
    end else if (w[1:0] != 2'b11) begin
      bad = 1'b1;
    end else begin
      case (op)
        rv64ie_pkg::OP_LOAD: begin
          if (f3 == 3'd7) begin
            bad = 1'b1;
          end else begin
            kind = rv64ie_pkg::KIND_READ;
            addr = a + immi;
            size = f3[1:0];
            pend_load = 1'b1;
          end
        end
        rv64ie_pkg::OP_FENCE: begin
        end
        rv64ie_pkg::OP_IMM: begin
          wen = 1'b1;
          case (f3)
            3'd0: v = a + immi;
            3'd1: begin
              if (top != 6'd0) bad = 1'b1;
              v = a << sh;
            end
            3'd2: v = {63'd0, $signed(a) < $signed(immi)};
            3'd3: v = {63'd0, a < immi};
            3'd4: v = a ^ immi;
            3'd5: begin
              if (top == 6'd0) v = a >> sh;
              else if (top == rv64ie_pkg::TOP_SRA) v = $unsigned($signed(a) >>> sh);
              else bad = 1'b1;
            end
            3'd6: v = a | immi;
            default: v = a & immi;
          endcase
        end
        rv64ie_pkg::OP_IMM32: begin
          wen = 1'b1;
          if (f3 == 3'd0) wv = lo + w[31:20] + {{20{w[31]}}, 12'd0};
          else if (f3 == 3'd1 && f7 == rv64ie_pkg::F7_BASE) wv = lo << sh[4:0];
          else if (f3 == 3'd5 && f7 == rv64ie_pkg::F7_BASE) wv = lo >> sh[4:0];
          else if (f3 == 3'd5 && f7 == rv64ie_pkg::F7_ALT) wv = $unsigned($signed(lo) >>> sh[4:0]);
          else bad = 1'b1;
          v = {{32{wv[31]}}, wv};
        end
        rv64ie_pkg::OP_STORE: begin
          if (f3[2]) begin
            bad = 1'b1;
          end else begin
            kind = rv64ie_pkg::KIND_WRITE;
            addr = a + imms;
            size = f3[1:0];
            sval = b;
          end
        end
        rv64ie_pkg::OP_AUIPC: begin
          wen = 1'b1;
          v = pc + immu;
        end
        rv64ie_pkg::OP_LUI: begin
          wen = 1'b1;
          v = immu;
        end
        rv64ie_pkg::OP_REG: begin
          wen = 1'b1;
          if (f7 == rv64ie_pkg::F7_MUL) begin
            if (f3 == 3'd0) v = prod;
            else bad = 1'b1;
          end else if (f7 == rv64ie_pkg::F7_BASE) begin
            case (f3)
              3'd0: v = a + b;
              3'd1: v = a << b[5:0];
              3'd2: v = {63'd0, $signed(a) < $signed(b)};
              3'd3: v = {63'd0, a < b};
              3'd4: v = a ^ b;
              3'd5: v = a >> b[5:0];
              3'd6: v = a | b;
              default: v = a & b;
            endcase
          end else if (f7 == rv64ie_pkg::F7_ALT && f3 == 3'd0) begin
            v = a - b;
          end else if (f7 == rv64ie_pkg::F7_ALT && f3 == 3'd5) begin
            v = $unsigned($signed(a) >>> b[5:0]);
          end else begin
            bad = 1'b1;
          end
        end
        rv64ie_pkg::OP_REG32: begin
          wen = 1'b1;
          if (f7 == rv64ie_pkg::F7_BASE && f3 == 3'd0) wv = lo + b[31:0];
          else if (f7 == rv64ie_pkg::F7_ALT && f3 == 3'd0) wv = lo - b[31:0];
          else if (f7 == rv64ie_pkg::F7_BASE && f3 == 3'd1) wv = lo << b[4:0];
          else if (f7 == rv64ie_pkg::F7_BASE && f3 == 3'd5) wv = lo >> b[4:0];
          else if (f7 == rv64ie_pkg::F7_ALT && f3 == 3'd5) wv = $unsigned($signed(lo) >>> b[4:0]);
          else bad = 1'b1;
          v = {{32{wv[31]}}, wv};
        end
        rv64ie_pkg::OP_BRANCH: begin
          case (f3)
            3'd0: t = (a == b);
            3'd1: t = (a != b);
            3'd4: t = $signed(a) < $signed(b);
            3'd5: t = $signed(a) >= $signed(b);
            3'd6: t = a < b;
            3'd7: t = a >= b;
            default: bad = 1'b1;
          endcase
          if (t) npc = pc + immb;
        end
        rv64ie_pkg::OP_JALR: begin
          if (f3 != 3'd0) bad = 1'b1;
          wen = 1'b1;
          v = pc + 64'd4;
          npc = (a + immi) & ~64'd1;
        end
        rv64ie_pkg::OP_JAL: begin
          wen = 1'b1;
          v = pc + 64'd4;
          npc = pc + immj;
        end
        rv64ie_pkg::OP_AMO, rv64ie_pkg::OP_SYSTEM: begin
          kind = rv64ie_pkg::KIND_SYSTEM;
          npc = pc;
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      kind = rv64ie_pkg::KIND_ILLEGAL;
      addr = '0;
      size = '0;
      sval = '0;
      npc  = pc;
      wen  = 1'b0;
      pend_load = 1'b0;
    end
    res.kind        = kind;
    res.mem_addr    = addr;
    res.mem_size    = size;
    res.store_value = sval;
    res.next_pc     = npc;
    wr.en   = mode ? 1'b1 : wen;
    wr.addr = mode ? pend_dest : rd;
    wr.data = mode ? ld : v;
  end
endmodule

// ===== dv/rv64i_integer_execute_test.sv =====
// Self-checking testbench for the RV64I execute unit with a built-in instruction predictor.
`timescale 1ns / 1ps
module rv64i_integer_execute_test;
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LD = 3'd3, F3_LB = 3'd0, F3_LWU = 3'd6, F3_BADLOAD = 3'd7;

  typedef struct {
    logic        mode;
    logic [31:0] word;
    logic [63:0] ldata;
    logic        pause;
  } instr_item_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;   // mode, instr_word, load_data, zero pad
  logic         m_tvalid;
  logic         m_tready;
  logic [199:0] m_tdata;   // kind, mem_addr, mem_size, store_value, next_pc, zero pad

  instr_item_t         pending_instrs[$];
  rv64ie_pkg::result_t expected_results[$];
  logic [63:0] arch_regs[32];
  logic [63:0] arch_pc;
  logic [4:0]  load_dest;
  logic [1:0]  load_size;
  logic        load_signed;
  logic        in_accepted;
  int          mismatches;
  int          results_seen;
  int          cycle;
  int          hold_cycles;
  bit          hold_done;

  rv64i_integer_execute DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] sext(logic [63:0] v, int bits);
    logic signed [63:0] t;
    t = v << (64 - bits);
    return t >>> (64 - bits);
  endfunction

  function automatic logic [63:0] rd_reg(logic [4:0] i);
    return (i != 5'd0) ? arch_regs[i] : 64'd0;
  endfunction

  function automatic rv64ie_pkg::result_t execute_instr(instr_item_t it);
    rv64ie_pkg::result_t r;
    logic [31:0] w;
    logic [63:0] a, b, immi, v, pc, npc, lo, off, d;
    logic [4:0] op, rd;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] sh, top;
    logic wr, bad, t;
    int bits;
    w = it.word;
    op = w[6:2]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = rd_reg(w[19:15]); b = rd_reg(w[24:20]);
    immi = sext({52'd0, w[31:20]}, 12);
    sh = w[25:20]; top = w[31:26];
    pc = arch_pc; npc = pc + 64'd4; v = '0; wr = 1'b0; bad = 1'b0; t = 1'b0;
    lo = {32'd0, a[31:0]};
    r = '0;
    r.kind = rv64ie_pkg::KIND_DONE;
    if (it.mode) begin
      bits = 8 << load_size;
      d = it.ldata;
      if (bits < 64) d = load_signed ? sext(d, bits) : (d & ((64'd1 << bits) - 64'd1));
      if (load_dest != 5'd0) arch_regs[load_dest] = d;
      npc = pc;
    end else if (w[1:0] != 2'b11) begin
      bad = 1'b1;
    end else begin
      case (op)
        rv64ie_pkg::OP_LOAD: begin
          if (f3 == F3_BADLOAD) bad = 1'b1;
          else begin
            r.kind = rv64ie_pkg::KIND_READ; r.mem_addr = a + immi; r.mem_size = f3[1:0];
            load_dest = rd; load_size = f3[1:0]; load_signed = !f3[2];
          end
        end
        rv64ie_pkg::OP_FENCE: ;
        rv64ie_pkg::OP_IMM: begin
          case (f3)
            F3_ADD: v = a + immi;
            F3_SLL: if (top != 6'd0) bad = 1'b1; else v = a << sh;
            F3_SLT: v = ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0;
            F3_SLTU: v = (a < immi) ? 64'd1 : 64'd0;
            F3_XOR: v = a ^ immi;
            F3_SR: if (top == 6'd0) v = a >> sh;
                   else if (top == rv64ie_pkg::TOP_SRA) v = $signed(a) >>> sh;
                   else bad = 1'b1;
            F3_OR: v = a | immi;
            default: v = a & immi;
          endcase
          wr = 1'b1;
        end
        rv64ie_pkg::OP_IMM32: begin
          if (f3 == F3_ADD) v = sext(a + immi, 32);
          else if (f3 == F3_SLL && f7 == rv64ie_pkg::F7_BASE) v = sext(lo << sh[4:0], 32);
          else if (f3 == F3_SR && f7 == rv64ie_pkg::F7_BASE) v = sext(lo >> sh[4:0], 32);
          else if (f3 == F3_SR && f7 == rv64ie_pkg::F7_ALT)
            v = sext($signed(sext(lo, 32)) >>> sh[4:0], 32);
          else bad = 1'b1;
          wr = 1'b1;
        end
        rv64ie_pkg::OP_STORE: begin
          if (f3 > 3'd3) bad = 1'b1;
          else begin
            r.kind = rv64ie_pkg::KIND_WRITE;
            r.mem_addr = a + sext({52'd0, w[31:25], w[11:7]}, 12);
            r.mem_size = f3[1:0]; r.store_value = b;
          end
        end
        rv64ie_pkg::OP_AUIPC: begin
          v = pc + sext({32'd0, w[31:12], 12'd0}, 32); wr = 1'b1;
        end
        rv64ie_pkg::OP_LUI: begin v = sext({32'd0, w[31:12], 12'd0}, 32); wr = 1'b1; end
        rv64ie_pkg::OP_REG: begin
          if (f7 == rv64ie_pkg::F7_MUL) begin
            if (f3 == F3_ADD) v = a * b; else bad = 1'b1;
          end else if (f7 == rv64ie_pkg::F7_BASE) begin
            case (f3)
              F3_ADD: v = a + b;
              F3_SLL: v = a << b[5:0];
              F3_SLT: v = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
              F3_SLTU: v = (a < b) ? 64'd1 : 64'd0;
              F3_XOR: v = a ^ b;
              F3_SR: v = a >> b[5:0];
              F3_OR: v = a | b;
              default: v = a & b;
            endcase
          end else if (f7 == rv64ie_pkg::F7_ALT && f3 == F3_ADD) v = a - b;
          else if (f7 == rv64ie_pkg::F7_ALT && f3 == F3_SR) v = $signed(a) >>> b[5:0];
          else bad = 1'b1;
          wr = 1'b1;
        end
        rv64ie_pkg::OP_REG32: begin
          if (f7 == rv64ie_pkg::F7_BASE && f3 == F3_ADD) v = sext(a + b, 32);
          else if (f7 == rv64ie_pkg::F7_ALT && f3 == F3_ADD) v = sext(a - b, 32);
          else if (f7 == rv64ie_pkg::F7_BASE && f3 == F3_SLL) v = sext(lo << b[4:0], 32);
          else if (f7 == rv64ie_pkg::F7_BASE && f3 == F3_SR) v = sext(lo >> b[4:0], 32);
          else if (f7 == rv64ie_pkg::F7_ALT && f3 == F3_SR)
            v = sext($signed(sext(lo, 32)) >>> b[4:0], 32);
          else bad = 1'b1;
          wr = 1'b1;
        end
        rv64ie_pkg::OP_BRANCH: begin
          off = sext({51'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
          case (f3)
            F3_BEQ: t = (a == b);
            F3_BNE: t = (a != b);
            F3_BLT: t = ($signed(a) < $signed(b));
            F3_BGE: t = ($signed(a) >= $signed(b));
            F3_BLTU: t = (a < b);
            F3_BGEU: t = (a >= b);
            default: bad = 1'b1;
          endcase
          if (t) npc = pc + off;
        end
        rv64ie_pkg::OP_JALR: begin
          if (f3 != 3'd0) bad = 1'b1;
          else begin v = pc + 64'd4; wr = 1'b1; npc = (a + immi) & ~64'd1; end
        end
        rv64ie_pkg::OP_JAL: begin
          off = sext({43'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
          v = pc + 64'd4; wr = 1'b1; npc = pc + off;
        end
        rv64ie_pkg::OP_AMO, rv64ie_pkg::OP_SYSTEM: begin
          r.kind = rv64ie_pkg::KIND_SYSTEM; npc = pc;
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      r = '0;
      r.kind = rv64ie_pkg::KIND_ILLEGAL;
    end else begin
      if (wr && rd != 5'd0) arch_regs[rd] = v;
      arch_pc = npc;
    end
    r.next_pc = arch_pc;
    return r;
  endfunction

  function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] r2, logic [4:0] r1,
                                      logic [2:0] f3, logic [4:0] rd, logic [4:0] op);
    return {f7, r2, r1, f3, rd, op, 2'b11};
  endfunction

  function automatic logic [31:0] random_word();
    logic [4:0] rd, r1, r2, op;
    logic [2:0] f3;
    logic [6:0] f7;
    int pick;
    rd = 5'($urandom); r1 = 5'($urandom); r2 = 5'($urandom);
    f3 = 3'($urandom); f7 = 7'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) return $urandom;
    case ($urandom_range(13))
      0: op = rv64ie_pkg::OP_LOAD;
      1: op = rv64ie_pkg::OP_FENCE;
      2: begin
        op = rv64ie_pkg::OP_IMM;
        if (f3 == F3_SLL || f3 == F3_SR)
          f7 = ($urandom_range(9) == 0) ? f7
             : {($urandom_range(1) ? rv64ie_pkg::TOP_SRA : 6'd0), f7[0]};
      end
      3: begin
        op = rv64ie_pkg::OP_IMM32;
        if ($urandom_range(5) != 0) f7 = $urandom_range(1) ? rv64ie_pkg::F7_ALT : rv64ie_pkg::F7_BASE;
      end
      4: begin op = rv64ie_pkg::OP_STORE; f3[2] = ($urandom_range(9) == 0); end
      5: op = rv64ie_pkg::OP_AUIPC;
      6, 7: begin
        op = rv64ie_pkg::OP_REG;
        if ($urandom_range(7) != 0)
          case ($urandom_range(2))
            0: f7 = rv64ie_pkg::F7_BASE;
            1: f7 = rv64ie_pkg::F7_ALT;
            default: f7 = rv64ie_pkg::F7_MUL;
          endcase
      end
      8: op = rv64ie_pkg::OP_LUI;
      9: begin
        op = rv64ie_pkg::OP_REG32;
        if ($urandom_range(5) != 0) f7 = $urandom_range(1) ? rv64ie_pkg::F7_ALT : rv64ie_pkg::F7_BASE;
      end
      10: op = rv64ie_pkg::OP_BRANCH;
      11: begin op = rv64ie_pkg::OP_JALR; if ($urandom_range(7) != 0) f3 = 3'd0; end
      12: op = rv64ie_pkg::OP_JAL;
      default: op = $urandom_range(1) ? rv64ie_pkg::OP_SYSTEM : rv64ie_pkg::OP_AMO;
    endcase
    return enc(f7, r2, r1, f3, rd, op);
  endfunction

  task automatic add_instr(logic [31:0] w);
    pending_instrs.push_back('{mode: 1'b0, word: w, ldata: {$urandom, $urandom}, pause: 1'b0});
  endtask

  task automatic add_return(logic [63:0] d);
    pending_instrs.push_back('{mode: 1'b1, word: $urandom, ldata: d, pause: 1'b0});
  endtask

  task automatic add_pause();
    pending_instrs.push_back('{mode: 1'b0, word: 32'd0, ldata: 64'd0, pause: 1'b1});
  endtask

  always @(negedge clk) begin
    if (!hold_done && results_seen >= 150) begin
      hold_done <= 1;
      hold_cycles <= 80;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(negedge clk) begin
    instr_item_t it;
    bit quiet;
    cycle <= cycle + 1;
    quiet = (cycle >= 300 && cycle < 550);
    if (rst) m_tready <= 0;
    else m_tready <= (hold_cycles == 0) && (quiet || $urandom_range(99) >= 33);
    if (!rst && (!s_tvalid || in_accepted)) begin
      if (pending_instrs.size() > 0 && pending_instrs[0].pause) begin
        if (expected_results.size() == 0) void'(pending_instrs.pop_front());
        s_tvalid <= 0;
      end else if (pending_instrs.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
        it = pending_instrs.pop_front();
        s_tdata <= {7'd0, it.ldata, it.word, it.mode};
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    rv64ie_pkg::result_t got, want;
    instr_item_t it;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind        = m_tdata[2:0];
        got.mem_addr    = m_tdata[66:3];
        got.mem_size    = m_tdata[68:67];
        got.store_value = m_tdata[132:69];
        got.next_pc     = m_tdata[196:133];
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction: %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.mem_addr !== want.mem_addr ||
              got.mem_size !== want.mem_size || got.store_value !== want.store_value ||
              got.next_pc !== want.next_pc) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected kind %0d addr %h size %0d store %h pc %h, got kind %0d addr %h size %0d store %h pc %h",
                       want.kind, want.mem_addr, want.mem_size, want.store_value, want.next_pc,
                       got.kind, got.mem_addr, got.mem_size, got.store_value, got.next_pc);
          end
        end
      end
      in_accepted = s_tvalid && s_tready;
      if (in_accepted) begin
        it.mode = s_tdata[0]; it.word = s_tdata[32:1]; it.ldata = s_tdata[96:33]; it.pause = 0;
        expected_results.push_back(execute_instr(it));
      end
    end
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n;
    rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0; in_accepted = 0;
    mismatches = 0; results_seen = 0; cycle = 0; hold_cycles = 0; hold_done = 0;
    foreach (arch_regs[i]) arch_regs[i] = 0;
    arch_pc = 0; load_dest = 0; load_size = 0; load_signed = 0;

    // Load return before any load: the data goes to x0 and is dropped.
    add_return('1);
    add_instr(enc(7'h7F, 5'h1F, 5'd0, F3_ADD, 5'd1, rv64ie_pkg::OP_LUI));
    add_instr(enc(7'h7F, 5'h1F, 5'd1, F3_ADD, 5'd1, rv64ie_pkg::OP_IMM));
    add_instr(enc(7'd0, 5'd1, 5'd1, F3_ADD, 5'd2, rv64ie_pkg::OP_REG));
    add_instr(enc(rv64ie_pkg::F7_MUL, 5'd1, 5'd2, F3_ADD, 5'd3, rv64ie_pkg::OP_REG));
    add_instr(enc(7'h3F, 5'h1F, 5'd1, F3_LD, 5'd4, rv64ie_pkg::OP_LOAD));
    add_return('1);
    add_instr(enc(7'd0, 5'd0, 5'd0, F3_LB, 5'd5, rv64ie_pkg::OP_LOAD));
    add_return(64'h0123_4567_89AB_CD80);
    add_instr(enc(7'd0, 5'd8, 5'd0, F3_LWU, 5'd6, rv64ie_pkg::OP_LOAD));
    add_return(64'hFFFF_FFFF_8000_0001);
    add_instr(enc({1'b0, rv64ie_pkg::TOP_SRA}, 5'h1F, 5'd5, F3_SR, 5'd7, rv64ie_pkg::OP_IMM));
    add_instr(enc(rv64ie_pkg::F7_ALT, 5'd6, 5'd5, F3_SR, 5'd8, rv64ie_pkg::OP_REG32));
    add_instr(enc(7'h7F, 5'd5, 5'd4, 3'd3, 5'h1F, rv64ie_pkg::OP_STORE));
    add_instr(enc(7'h7F, 5'h1F, 5'd0, 3'd0, 5'd9, rv64ie_pkg::OP_JAL));
    add_instr(enc(7'd0, 5'd0, 5'd9, 3'd0, 5'd10, rv64ie_pkg::OP_JALR));
    add_instr(enc(7'h3F, 5'd1, 5'd5, F3_BLT, 5'd1, rv64ie_pkg::OP_BRANCH));
    add_instr(enc(7'd0, 5'd0, 5'd0, 3'd7, 5'd0, rv64ie_pkg::OP_FENCE));
    add_instr(enc(7'd0, 5'd0, 5'd0, 3'd0, 5'd0, rv64ie_pkg::OP_SYSTEM));
    add_instr(enc(7'd0, 5'd1, 5'd2, 3'd2, 5'd3, rv64ie_pkg::OP_AMO));
    add_instr(32'hFFFF_FFFC);
    add_instr(enc(rv64ie_pkg::F7_MUL, 5'd1, 5'd2, F3_XOR, 5'd3, rv64ie_pkg::OP_REG));
    add_instr(enc(7'h10, 5'd1, 5'd2, F3_SLL, 5'd3, rv64ie_pkg::OP_IMM));
    add_instr(enc(7'd0, 5'd1, 5'd2, 3'd2, 5'd3, rv64ie_pkg::OP_BRANCH));
    add_instr(enc(7'd0, 5'd1, 5'd2, 3'd0, 5'd3, 5'h1F));
    add_pause();

    n = 0;
    while (n < 450) begin
      if ($urandom_range(99) < 20) begin
        add_instr(enc(7'($urandom), 5'($urandom), 5'($urandom),
                      {1'($urandom_range(1)), 2'($urandom)}, 5'($urandom),
                      rv64ie_pkg::OP_LOAD));
        add_return({$urandom, $urandom});
        n += 2;
      end else if ($urandom_range(99) < 3) begin
        add_return({$urandom, $urandom});
        n++;
      end else begin
        add_instr(random_word());
        n++;
      end
      if (n == 250) add_pause();
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (pending_instrs.size() == 0);
    do @(posedge clk); while (s_tvalid || expected_results.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
